// ===== hw/rtl/psc_pkg.sv =====
// Shared widths, types and constants of the pair-sum counter.
package psc_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int FREQ_BITS   = 16;
    localparam int TARGET_BITS = 17;
    localparam int COUNT_BITS  = 32;
    localparam int EPOCH_BITS  = 8;

    localparam int DIFF_BITS  = ((TARGET_BITS > VALUE_BITS) ? TARGET_BITS : VALUE_BITS) + 1;
    localparam int TABLE_DEPTH = 1 << VALUE_BITS;
    localparam int ENTRY_BITS = EPOCH_BITS + FREQ_BITS;

    localparam logic [FREQ_BITS-1:0]  FREQ_MAX   = {FREQ_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = {EPOCH_BITS{1'b1}};
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_FREE  = '0;

    typedef logic signed [VALUE_BITS-1:0]  value_t;
    typedef logic signed [TARGET_BITS-1:0] target_t;
    typedef logic [VALUE_BITS-1:0]         addr_t;
    typedef logic [FREQ_BITS-1:0]          freq_t;
    typedef logic [COUNT_BITS-1:0]         count_t;
    typedef logic [EPOCH_BITS-1:0]         epoch_t;

    typedef struct packed {
        epoch_t epoch;
        freq_t  freq;
    } entry_t;

    typedef struct packed {
        count_t pair_count;
        logic   saturated;
    } result_t;

endpackage

// ===== hw/rtl/psc_if.sv =====
// Valid/ready channel interfaces for input values and results.
interface psc_item_if
    import psc_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface psc_result_if
    import psc_pkg::*;
();
    logic   valid;
    logic   ready;
    count_t pair_count;
    logic   saturated;

    modport source (output valid, output pair_count, output saturated, input ready);
    modport sink   (input valid, input pair_count, input saturated, output ready);
endinterface

// ===== hw/rtl/pair_sum_counter.sv =====
// Top level: streaming two-sum pair counter over an epoch-tagged frequency RAM.
//
//  channel  | dir | payload                         | beat taken when
//  ---------+-----+---------------------------------+------------------------
//  item     | in  | value[15:0] signed, last        | item.valid & item.ready
//  result   | out | pair_count[31:0], saturated     | result.valid & result.ready
//  cfg      | in  | cfg_wr_data[16:0] (target_sum)  | cfg_wr_en
//
// One beat per cycle sustained while item.ready is high. Stage 0 issues two reads
// (partner slot and own slot) into the frequency RAM; stage 1 adds, saturates and
// writes back, with the previous write forwarded. The last beat is registered in
// stage 1 and its result then in the result queue. After reset, and after every
// 255th array, a clearing pass sweeps all 65536 RAM entries with item.ready low;
// other arrays are retired by bumping the epoch tag. A two-deep result queue absorbs output stalls.
module pair_sum_counter
    import psc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  target_t             cfg_wr_data,
    psc_item_if.sink            item,
    psc_result_if.source        result
);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t  state_reg, state_next;
    addr_t   clr_addr_reg, clr_addr_next;
    epoch_t  epoch_reg, epoch_next;
    target_t target_sum_reg;

    // frequency RAM, tag + count per entry
    entry_t  freq_mem [TABLE_DEPTH];
    entry_t  rd_part_reg, rd_own_reg;

    // stage 1 control
    logic    s1_valid_reg;
    logic    s1_last_reg;
    logic    s1_in_range_reg;
    addr_t   s1_part_reg;
    addr_t   s1_own_reg;

    // forwarding of the write done at the previous edge
    logic    fwd_valid_reg;
    addr_t   fwd_addr_reg;
    entry_t  fwd_data_reg;

    count_t  count_reg, count_next;
    logic    ovf_reg, ovf_next;

    // result queue
    result_t q_mem_reg [2];
    logic    q_wr_ptr_reg, q_rd_ptr_reg;
    logic [1:0] q_cnt_reg, q_cnt_next;

    // stage 0
    logic    accept;
    logic signed [DIFF_BITS-1:0] diff;
    logic    in_range;
    logic [DIFF_BITS-VALUE_BITS:0] diff_top;

    // stage 1 datapath
    entry_t  part_ent, own_ent;
    freq_t   part_freq, own_freq, own_freq_new;
    logic [COUNT_BITS:0] sum;
    count_t  count_upd;
    logic    cnt_sat, freq_sat;
    logic    mem_we;
    addr_t   mem_waddr;
    entry_t  mem_wdata;
    logic    q_push, q_pop;
    logic    wrap_pending;

    // ---------------- input side ----------------
    // hold off while an array closes on the last epoch (clearing pass follows)
    assign wrap_pending = s1_valid_reg && s1_last_reg && (epoch_reg == EPOCH_LAST);
    assign item.ready   = (state_reg == ST_RUN) && !wrap_pending
                          && ((3'(q_cnt_reg) + 3'(s1_valid_reg && s1_last_reg)) < 3'd2);
    assign accept       = item.valid && item.ready;

    assign diff     = DIFF_BITS'(target_sum_reg) - DIFF_BITS'(item.value);
    assign diff_top = diff[DIFF_BITS-1:VALUE_BITS-1];
    assign in_range = (diff_top == '0) || (diff_top == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            target_sum_reg <= cfg_wr_data;
        end
    end

    // ---------------- memory ----------------
    always_ff @(posedge clk)
    begin
        rd_part_reg <= freq_mem[diff[VALUE_BITS-1:0]];
        rd_own_reg  <= freq_mem[addr_t'(item.value)];
        if (mem_we)
        begin
            freq_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_part_reg     <= diff[VALUE_BITS-1:0];
        s1_own_reg      <= addr_t'(item.value);
        s1_in_range_reg <= in_range;
        s1_last_reg     <= item.last;
        fwd_addr_reg    <= mem_waddr;
        fwd_data_reg    <= mem_wdata;
    end

    // ---------------- stage 1 ----------------
    always_comb
    begin
        part_ent = (fwd_valid_reg && (fwd_addr_reg == s1_part_reg)) ? fwd_data_reg : rd_part_reg;
        own_ent  = (fwd_valid_reg && (fwd_addr_reg == s1_own_reg)) ? fwd_data_reg : rd_own_reg;
        // stale tag means the entry is free or belongs to an earlier array
        part_freq = (part_ent.epoch == epoch_reg) ? part_ent.freq : '0;
        own_freq  = (own_ent.epoch == epoch_reg) ? own_ent.freq : '0;

        sum = {1'b0, count_reg}
              + (s1_in_range_reg ? (COUNT_BITS+1)'(part_freq) : '0);
        cnt_sat   = (sum >= (COUNT_BITS+1)'(COUNT_MAX));
        count_upd = cnt_sat ? COUNT_MAX : sum[COUNT_BITS-1:0];

        own_freq_new = (own_freq == FREQ_MAX) ? FREQ_MAX : own_freq + FREQ_BITS'(1);
        freq_sat     = (own_freq_new == FREQ_MAX);

        ovf_next   = ovf_reg;
        count_next = count_reg;
        q_push     = 1'b0;
        if (s1_valid_reg)
        begin
            ovf_next   = ovf_reg || cnt_sat || freq_sat;
            count_next = count_upd;
            if (s1_last_reg)
            begin
                q_push     = 1'b1;
                ovf_next   = 1'b0;
                count_next = '0;
            end
        end

        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '{epoch: EPOCH_FREE, freq: '0};
        end
        else
        begin
            mem_we    = s1_valid_reg;
            mem_waddr = s1_own_reg;
            mem_wdata = '{epoch: epoch_reg, freq: own_freq_new};
        end
    end

    // ---------------- sequencing ----------------
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        epoch_next    = epoch_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + VALUE_BITS'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_RUN;
                    epoch_next = EPOCH_FIRST;
                end
            end
            ST_RUN:
            begin
                if (s1_valid_reg && s1_last_reg)
                begin
                    if (epoch_reg == EPOCH_LAST)
                    begin
                        state_next    = ST_CLEAR;
                        clr_addr_next = '0;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + EPOCH_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next    = ST_CLEAR;
                clr_addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            epoch_reg     <= EPOCH_FIRST;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            epoch_reg     <= epoch_next;
            s1_valid_reg  <= accept;
            fwd_valid_reg <= mem_we;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
        end
    end

    // ---------------- result queue ----------------
    assign q_pop  = result.valid && result.ready;
    assign result.valid      = (q_cnt_reg != 2'd0);
    assign result.pair_count = q_mem_reg[q_rd_ptr_reg].pair_count;
    assign result.saturated  = q_mem_reg[q_rd_ptr_reg].saturated;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        priority if (q_push && !q_pop)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (q_pop && !q_push)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
        else
        begin
            q_cnt_next = q_cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[q_wr_ptr_reg] <= '{pair_count: count_upd,
                                         saturated: ovf_reg || cnt_sat || freq_sat};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_cnt_reg    <= 2'd0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (q_push)
            begin
                q_wr_ptr_reg <= !q_wr_ptr_reg;
            end
            if (q_pop)
            begin
                q_rd_ptr_reg <= !q_rd_ptr_reg;
            end
        end
    end

endmodule
